// ----- sv/tgbm_pkg.sv -----
// shared types, constants and helpers for the triangle grid bin mask block
// no dependencies; used by tgbm_axis_grid and triangle_grid_bin_mask_top
`default_nettype none

package tgbm_pkg;

    localparam int COORD_W     = 16;
    localparam int FLAGS_W     = 32;
    localparam int XZ_MASK_W   = 32;
    localparam int Y_MASK_W    = 8;
    localparam int Z_BIT_BASE  = 16;
    localparam int XZ_BINS_DEF = 16;
    localparam int Y_BINS_DEF  = 8;
    localparam int CFG_INDEX_W = 3;

    localparam logic [FLAGS_W-1:0] SKIP_SET_BITS   = 32'h0000_1080;
    localparam logic [FLAGS_W-1:0] SKIP_CLEAR_BITS = 32'h0801_0000;

    localparam logic signed [COORD_W-1:0] BOX_SENTINEL = 16'sh7FBC;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_X_LIMIT  = 3'd1,
        CFG_Z_ORIGIN = 3'd2,
        CFG_Z_LIMIT  = 3'd3,
        CFG_Y_ORIGIN = 3'd4,
        CFG_Y_LIMIT  = 3'd5
    } cfg_index_t;

    function automatic coord_t coord_min(input coord_t a, input coord_t b);
        return (b < a) ? b : a;
    endfunction

    function automatic coord_t coord_max(input coord_t a, input coord_t b);
        return (a < b) ? b : a;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tgbm_axis_grid.sv -----
// bin edge generator for one axis: step = floor((limit-origin)/BINS)+1, edges origin+k*step
// depends on tgbm_pkg; new origin or limit settles via dprime_reg, prod_reg, bin_edge_reg
`default_nettype none

module tgbm_axis_grid #(
    parameter int BINS = tgbm_pkg::XZ_BINS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tgbm_pkg::coord_t                    origin,
    input  wire tgbm_pkg::coord_t                    limit,
    output logic [BINS:0][tgbm_pkg::COORD_W-1:0]     bin_edge
);

    localparam int CW = tgbm_pkg::COORD_W;

    // biased difference stays positive and below 2^DIV_W
    localparam int DIV_W  = $clog2((BINS + 1) * (1 << CW));
    localparam int SHIFT_L = $clog2(BINS);
    localparam int REC_S  = DIV_W + SHIFT_L;
    localparam int REC_W  = DIV_W + 1;
    localparam int PROD_W = DIV_W + REC_W;
    localparam longint unsigned RECIP    = ((64'd1 << REC_S) + BINS - 1) / BINS;
    localparam longint unsigned DIV_BIAS = 64'(BINS) << CW;
    localparam longint unsigned RST_PROD = DIV_BIAS * RECIP;

    logic [DIV_W-1:0]           dprime_reg, dprime_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [BINS:0][CW-1:0]      bin_edge_reg, bin_edge_next;
    logic [CW-1:0]              step;

    always_comb
    begin
        dprime_next = DIV_W'(DIV_BIAS)
                    + {{(DIV_W-CW){limit[CW-1]}}, limit}
                    - {{(DIV_W-CW){origin[CW-1]}}, origin};
        prod_next   = PROD_W'(dprime_reg) * PROD_W'(RECIP);
        // the bias adds a multiple of 2^16 to the quotient, gone in the low bits
        step        = prod_reg[REC_S +: CW] + CW'(1);
        for (int k = 0; k <= BINS; k++)
        begin
            bin_edge_next[k] = CW'(origin) + CW'(CW'(k) * step);
        end
    end

    // reset values match origin = limit = 0, so items may enter right after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dprime_reg <= DIV_W'(DIV_BIAS);
            prod_reg   <= PROD_W'(RST_PROD);
            for (int k = 0; k <= BINS; k++)
            begin
                bin_edge_reg[k] <= CW'(k);
            end
        end
        else
        begin
            dprime_reg   <= dprime_next;
            prod_reg     <= prod_next;
            bin_edge_reg <= bin_edge_next;
        end
    end

    assign bin_edge = bin_edge_reg;

endmodule

`default_nettype wire

// ----- sv/triangle_grid_bin_mask_top.sv -----
// triangle grid bin mask: bounding box of a triangle tested against x, z and y bin grids
// one word per cycle sustained while m_tready is high; an accepted input word reaches m_tvalid
// via four pipeline stages (input, box pair, box final, bin compare) with skid-free stalls
// reset clears valid bits and the six config registers to zero; bin edges come from config
// via dprime_reg, prod_reg, bin_edge_reg, set before a word accepted after a write is compared
`default_nettype none

module triangle_grid_bin_mask_top #(
    parameter int XZ_BINS = tgbm_pkg::XZ_BINS_DEF,
    parameter int Y_BINS  = tgbm_pkg::Y_BINS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // config write port
    input  wire logic                                cfg_wen,
    input  wire logic [tgbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tgbm_pkg::COORD_W-1:0]        cfg_data,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [9*tgbm_pkg::COORD_W-1:0]      s_tdata,   // ax, ay, az, bx, by, bz, cx, cy, cz
    input  wire logic [tgbm_pkg::FLAGS_W-1:0]        s_tuser,   // group_flags
    // output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [tgbm_pkg::XZ_MASK_W+tgbm_pkg::Y_MASK_W-1:0] m_tdata  // xz_mask, y_mask
);

    localparam int CW     = tgbm_pkg::COORD_W;
    localparam int Y_KEPT = (Y_BINS < tgbm_pkg::Y_MASK_W) ? Y_BINS : tgbm_pkg::Y_MASK_W;

    typedef struct packed {
        tgbm_pkg::coord_t lo_ab;
        tgbm_pkg::coord_t hi_ab;
        tgbm_pkg::coord_t lo_c;
        tgbm_pkg::coord_t hi_c;
    } part_box_t;

    typedef struct packed {
        tgbm_pkg::coord_t lo;
        tgbm_pkg::coord_t hi;
    } box_t;

    // config registers
    tgbm_pkg::coord_t x_origin_reg, x_limit_reg, z_origin_reg, z_limit_reg;
    tgbm_pkg::coord_t y_origin_reg, y_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            x_limit_reg  <= '0;
            z_origin_reg <= '0;
            z_limit_reg  <= '0;
            y_origin_reg <= '0;
            y_limit_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                tgbm_pkg::CFG_X_ORIGIN: x_origin_reg <= cfg_data;
                tgbm_pkg::CFG_X_LIMIT:  x_limit_reg  <= cfg_data;
                tgbm_pkg::CFG_Z_ORIGIN: z_origin_reg <= cfg_data;
                tgbm_pkg::CFG_Z_LIMIT:  z_limit_reg  <= cfg_data;
                tgbm_pkg::CFG_Y_ORIGIN: y_origin_reg <= cfg_data;
                tgbm_pkg::CFG_Y_LIMIT:  y_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // bin edges per axis
    logic [XZ_BINS:0][CW-1:0] x_edge, z_edge;
    logic [Y_BINS:0][CW-1:0]  y_edge;

    tgbm_axis_grid #(.BINS(XZ_BINS)) u_x_grid (
        .clk(clk), .rst_n(rst_n), .origin(x_origin_reg), .limit(x_limit_reg), .bin_edge(x_edge)
    );

    tgbm_axis_grid #(.BINS(XZ_BINS)) u_z_grid (
        .clk(clk), .rst_n(rst_n), .origin(z_origin_reg), .limit(z_limit_reg), .bin_edge(z_edge)
    );

    tgbm_axis_grid #(.BINS(Y_BINS)) u_y_grid (
        .clk(clk), .rst_n(rst_n), .origin(y_origin_reg), .limit(y_limit_reg), .bin_edge(y_edge)
    );

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;

    assign ready4   = !v4_reg || m_tready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= s_tvalid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: input word and skip decode
    logic [9*CW-1:0] s1_vtx_reg;
    logic            s1_skip_reg, s1_skip_next;

    assign s1_skip_next = ((s_tuser & tgbm_pkg::SKIP_SET_BITS) != '0)
                       && ((s_tuser & tgbm_pkg::SKIP_CLEAR_BITS) == '0);

    // stage 2: pairwise min/max, third vertex clamped against the sentinels
    part_box_t s2_x_reg, s2_y_reg, s2_z_reg;
    part_box_t s2_x_next, s2_y_next, s2_z_next;
    logic      s2_skip_reg;

    function automatic part_box_t part_box(input tgbm_pkg::coord_t a, input tgbm_pkg::coord_t b,
                                           input tgbm_pkg::coord_t c);
        part_box_t p;
        p.lo_ab = tgbm_pkg::coord_min(a, b);
        p.hi_ab = tgbm_pkg::coord_max(a, b);
        p.lo_c  = tgbm_pkg::coord_min(c, tgbm_pkg::BOX_SENTINEL);
        p.hi_c  = tgbm_pkg::coord_max(c, -tgbm_pkg::BOX_SENTINEL);
        return p;
    endfunction

    function automatic box_t merge_box(input part_box_t p);
        box_t b;
        b.lo = tgbm_pkg::coord_min(p.lo_ab, p.lo_c);
        b.hi = tgbm_pkg::coord_max(p.hi_ab, p.hi_c);
        return b;
    endfunction

    always_comb
    begin
        s2_x_next = part_box(s1_vtx_reg[0*CW +: CW], s1_vtx_reg[3*CW +: CW],
                             s1_vtx_reg[6*CW +: CW]);
        s2_y_next = part_box(s1_vtx_reg[1*CW +: CW], s1_vtx_reg[4*CW +: CW],
                             s1_vtx_reg[7*CW +: CW]);
        s2_z_next = part_box(s1_vtx_reg[2*CW +: CW], s1_vtx_reg[5*CW +: CW],
                             s1_vtx_reg[8*CW +: CW]);
    end

    // stage 3: final bounding box
    box_t s3_x_reg, s3_y_reg, s3_z_reg;
    logic s3_skip_reg;

    // stage 4: bin compare into output word
    logic [XZ_BINS-1:0]              x_bits, z_bits;
    logic [Y_BINS-1:0]               y_bits;
    logic [tgbm_pkg::XZ_MASK_W-1:0]  xz_mask_reg, xz_mask_next;
    logic [tgbm_pkg::Y_MASK_W-1:0]   y_mask_reg, y_mask_next;

    always_comb
    begin
        for (int k = 0; k < XZ_BINS; k++)
        begin
            x_bits[k] = ($signed(x_edge[k+1]) >= s3_x_reg.lo)
                     && (s3_x_reg.hi >= $signed(x_edge[k]));
            z_bits[k] = ($signed(z_edge[k+1]) >= s3_z_reg.lo)
                     && (s3_z_reg.hi >= $signed(z_edge[k]));
        end
        for (int k = 0; k < Y_BINS; k++)
        begin
            y_bits[k] = ($signed(y_edge[k+1]) >= s3_y_reg.lo)
                     && (s3_y_reg.hi >= $signed(y_edge[k]));
        end
        xz_mask_next = '0;
        y_mask_next  = '0;
        for (int k = 0; k < XZ_BINS; k++)
        begin
            xz_mask_next[k]                       = x_bits[k] && !s3_skip_reg;
            xz_mask_next[tgbm_pkg::Z_BIT_BASE + k] = z_bits[k] && !s3_skip_reg;
        end
        for (int k = 0; k < Y_KEPT; k++)
        begin
            y_mask_next[k] = y_bits[k] && !s3_skip_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            s1_vtx_reg  <= s_tdata;
            s1_skip_reg <= s1_skip_next;
        end
        if (ready2)
        begin
            s2_x_reg    <= s2_x_next;
            s2_y_reg    <= s2_y_next;
            s2_z_reg    <= s2_z_next;
            s2_skip_reg <= s1_skip_reg;
        end
        if (ready3)
        begin
            s3_x_reg    <= merge_box(s2_x_reg);
            s3_y_reg    <= merge_box(s2_y_reg);
            s3_z_reg    <= merge_box(s2_z_reg);
            s3_skip_reg <= s2_skip_reg;
        end
        if (ready4)
        begin
            xz_mask_reg <= xz_mask_next;
            y_mask_reg  <= y_mask_next;
        end
    end

    assign m_tdata = {y_mask_reg, xz_mask_reg};

    // a skipped triangle leaves the compare stage as an all-zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && s3_skip_reg && ready4) |=> (m_tdata == '0))
        else $error("skipped triangle produced a nonzero mask");

    // any empty stage lets a new word in
    assert property (@(posedge clk) disable iff (!rst_n)
        !(v1_reg && v2_reg && v3_reg && v4_reg) |-> s_tready)
        else $error("input stalled while the pipeline has a free stage");

    // an output word only appears when stage 3 held one
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(v3_reg))
        else $error("output valid without a word in the compare stage");

    // during an output stall the words held in stages 3 and 4 both stay valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !m_tready && v3_reg) |=> (v3_reg && v4_reg))
        else $error("stage 3 word dropped during an output stall");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for triangle_grid_bin_mask_top: random and corner triangles streamed
// through the block, expected bin masks computed in the bench; depends on tgbm_pkg
`default_nettype none

module tb_top;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_MODE = 64;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        tgbm_pkg::coord_t                ax, ay, az;
        tgbm_pkg::coord_t                bx, by, bz;
        tgbm_pkg::coord_t                cx, cy, cz;
        logic [tgbm_pkg::FLAGS_W-1:0]    flags;
    } triangle_t;

    typedef struct {
        logic [tgbm_pkg::XZ_MASK_W-1:0]  xz;
        logic [tgbm_pkg::Y_MASK_W-1:0]   y;
    } bin_masks_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic [tgbm_pkg::CFG_INDEX_W-1:0] cfg_index = tgbm_pkg::CFG_X_ORIGIN;
    logic [tgbm_pkg::COORD_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [9*tgbm_pkg::COORD_W-1:0] s_tdata = '0;   // ax, ay, az, bx, by, bz, cx, cy, cz
    logic [tgbm_pkg::FLAGS_W-1:0] s_tuser = '0;     // group_flags
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [tgbm_pkg::XZ_MASK_W+tgbm_pkg::Y_MASK_W-1:0] m_tdata; // xz_mask, y_mask

    // grid registers as the block should hold them, indexed by cfg_index_t
    tgbm_pkg::coord_t grid_cfg [6];

    bin_masks_t pending_masks [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int triangles_sent = 0;
    int masks_checked = 0;
    int skipped_seen = 0;
    int grid_settings = 0;
    int errors = 0;
    int cycles = 0;

    triangle_grid_bin_mask_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at %0t after %0d cycles, %0d masks outstanding",
                     $realtime, cycles, pending_masks.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // bins of one axis overlapped by the span bmin..bmax, bin k in bit k
    function automatic logic [31:0] axis_hits(tgbm_pkg::coord_t org, tgbm_pkg::coord_t lim,
                                              int nbins, int bmin, int bmax);
        int diff;
        int quot;
        int step_full;
        tgbm_pkg::coord_t step;
        tgbm_pkg::coord_t lo_edge;
        tgbm_pkg::coord_t hi_edge;
        logic [31:0] bits;
        bits = '0;
        diff = int'(lim) - int'(org);
        // floor division, rounding toward minus infinity
        if (diff >= 0)
            quot = diff / nbins;
        else
            quot = -((-diff + nbins - 1) / nbins);
        step_full = quot + 1;
        step = step_full[tgbm_pkg::COORD_W-1:0];
        lo_edge = org;
        hi_edge = org + step;
        for (int k = 0; k < nbins; k++)
        begin
            if (int'(hi_edge) >= bmin && bmax >= int'(lo_edge))
                bits[k] = 1'b1;
            lo_edge = lo_edge + step;
            hi_edge = hi_edge + step;
        end
        return bits;
    endfunction

    // box edges start at the sentinels, so far-out coordinates leave them clamped
    function automatic void box_span(tgbm_pkg::coord_t a, tgbm_pkg::coord_t b,
                                     tgbm_pkg::coord_t c, output int lo, output int hi);
        int v [3];
        v[0] = int'(a);
        v[1] = int'(b);
        v[2] = int'(c);
        lo = int'(tgbm_pkg::BOX_SENTINEL);
        hi = -int'(tgbm_pkg::BOX_SENTINEL);
        for (int i = 0; i < 3; i++)
        begin
            if (hi < v[i])
                hi = v[i];
            if (v[i] < lo)
                lo = v[i];
        end
    endfunction

    function automatic bin_masks_t bin_masks_for(triangle_t t);
        bin_masks_t m;
        int xlo, xhi, ylo, yhi, zlo, zhi;
        logic [31:0] xbits, zbits, ybits;
        m.xz = '0;
        m.y = '0;
        if ((t.flags & tgbm_pkg::SKIP_SET_BITS) != '0
            && (t.flags & tgbm_pkg::SKIP_CLEAR_BITS) == '0)
            return m;
        box_span(t.ax, t.bx, t.cx, xlo, xhi);
        box_span(t.ay, t.by, t.cy, ylo, yhi);
        box_span(t.az, t.bz, t.cz, zlo, zhi);
        xbits = axis_hits(grid_cfg[tgbm_pkg::CFG_X_ORIGIN], grid_cfg[tgbm_pkg::CFG_X_LIMIT],
                          tgbm_pkg::XZ_BINS_DEF, xlo, xhi);
        zbits = axis_hits(grid_cfg[tgbm_pkg::CFG_Z_ORIGIN], grid_cfg[tgbm_pkg::CFG_Z_LIMIT],
                          tgbm_pkg::XZ_BINS_DEF, zlo, zhi);
        ybits = axis_hits(grid_cfg[tgbm_pkg::CFG_Y_ORIGIN], grid_cfg[tgbm_pkg::CFG_Y_LIMIT],
                          tgbm_pkg::Y_BINS_DEF, ylo, yhi);
        m.xz = {zbits[15:0], xbits[15:0]};
        m.y = ybits[tgbm_pkg::Y_MASK_W-1:0];
        return m;
    endfunction

    // receiver stalls
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        bin_masks_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_masks.size() == 0)
            begin
                $display("%0t: unexpected word, actual xz_mask %h y_mask %h",
                         $realtime, m_tdata[tgbm_pkg::XZ_MASK_W-1:0],
                         m_tdata[tgbm_pkg::XZ_MASK_W +: tgbm_pkg::Y_MASK_W]);
                errors++;
            end
            else
            begin
                want = pending_masks.pop_front();
                masks_checked++;
                if (want.xz == '0 && want.y == '0)
                    skipped_seen++;
                if (m_tdata[tgbm_pkg::XZ_MASK_W-1:0] !== want.xz)
                begin
                    $display("%0t: xz_mask mismatch, expected %h actual %h",
                             $realtime, want.xz, m_tdata[tgbm_pkg::XZ_MASK_W-1:0]);
                    errors++;
                end
                if (m_tdata[tgbm_pkg::XZ_MASK_W +: tgbm_pkg::Y_MASK_W] !== want.y)
                begin
                    $display("%0t: y_mask mismatch, expected %h actual %h",
                             $realtime, want.y,
                             m_tdata[tgbm_pkg::XZ_MASK_W +: tgbm_pkg::Y_MASK_W]);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(tgbm_pkg::cfg_index_t idx, tgbm_pkg::coord_t value);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        grid_cfg[idx] = value;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic load_grid(tgbm_pkg::coord_t xo, tgbm_pkg::coord_t xl,
                             tgbm_pkg::coord_t zo, tgbm_pkg::coord_t zl,
                             tgbm_pkg::coord_t yo, tgbm_pkg::coord_t yl);
        write_reg(tgbm_pkg::CFG_X_ORIGIN, xo);
        write_reg(tgbm_pkg::CFG_X_LIMIT, xl);
        write_reg(tgbm_pkg::CFG_Z_ORIGIN, zo);
        write_reg(tgbm_pkg::CFG_Z_LIMIT, zl);
        write_reg(tgbm_pkg::CFG_Y_ORIGIN, yo);
        write_reg(tgbm_pkg::CFG_Y_LIMIT, yl);
        grid_settings++;
    endtask

    task automatic send_triangle(triangle_t t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t.cz, t.cy, t.cx, t.bz, t.by, t.bx, t.az, t.ay, t.ax};
        s_tuser <= t.flags;
        do
            @(posedge clk);
        while (!s_tready);
        pending_masks.push_back(bin_masks_for(t));
        triangles_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
    endtask

    function automatic triangle_t make_triangle(tgbm_pkg::coord_t a, tgbm_pkg::coord_t b,
                                                tgbm_pkg::coord_t c,
                                                logic [tgbm_pkg::FLAGS_W-1:0] flags);
        triangle_t t;
        t.ax = a; t.ay = a; t.az = a;
        t.bx = b; t.by = b; t.bz = b;
        t.cx = c; t.cy = c; t.cz = c;
        t.flags = flags;
        return t;
    endfunction

    // mostly near the configured span of the axis, some anywhere, some at the extremes
    function automatic tgbm_pkg::coord_t rand_coord(tgbm_pkg::coord_t org,
                                                    tgbm_pkg::coord_t lim);
        int lo, hi, v, sel;
        tgbm_pkg::coord_t extremes [7];
        extremes = '{16'sh7FFF, -16'sh8000, tgbm_pkg::BOX_SENTINEL,
                     tgbm_pkg::BOX_SENTINEL + 16'sd1, -tgbm_pkg::BOX_SENTINEL,
                     -tgbm_pkg::BOX_SENTINEL - 16'sd1, 16'sd0};
        lo = (int'(org) < int'(lim)) ? int'(org) : int'(lim);
        hi = (int'(org) < int'(lim)) ? int'(lim) : int'(org);
        sel = $urandom_range(9);
        if (sel < 6)
        begin
            v = lo - 64 + int'($urandom_range(hi - lo + 128));
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return tgbm_pkg::coord_t'(v);
        end
        else if (sel < 8)
            return tgbm_pkg::coord_t'($urandom_range(16'hFFFF));
        return extremes[$urandom_range(6)];
    endfunction

    function automatic triangle_t rand_triangle();
        triangle_t t;
        t.ax = rand_coord(grid_cfg[tgbm_pkg::CFG_X_ORIGIN], grid_cfg[tgbm_pkg::CFG_X_LIMIT]);
        t.bx = rand_coord(grid_cfg[tgbm_pkg::CFG_X_ORIGIN], grid_cfg[tgbm_pkg::CFG_X_LIMIT]);
        t.cx = rand_coord(grid_cfg[tgbm_pkg::CFG_X_ORIGIN], grid_cfg[tgbm_pkg::CFG_X_LIMIT]);
        t.ay = rand_coord(grid_cfg[tgbm_pkg::CFG_Y_ORIGIN], grid_cfg[tgbm_pkg::CFG_Y_LIMIT]);
        t.by = rand_coord(grid_cfg[tgbm_pkg::CFG_Y_ORIGIN], grid_cfg[tgbm_pkg::CFG_Y_LIMIT]);
        t.cy = rand_coord(grid_cfg[tgbm_pkg::CFG_Y_ORIGIN], grid_cfg[tgbm_pkg::CFG_Y_LIMIT]);
        t.az = rand_coord(grid_cfg[tgbm_pkg::CFG_Z_ORIGIN], grid_cfg[tgbm_pkg::CFG_Z_LIMIT]);
        t.bz = rand_coord(grid_cfg[tgbm_pkg::CFG_Z_ORIGIN], grid_cfg[tgbm_pkg::CFG_Z_LIMIT]);
        t.cz = rand_coord(grid_cfg[tgbm_pkg::CFG_Z_ORIGIN], grid_cfg[tgbm_pkg::CFG_Z_LIMIT]);
        // random flag words hit the skip case about one time in seven
        case ($urandom_range(7))
            0: t.flags = '0;
            1: t.flags = $urandom() & ~tgbm_pkg::SKIP_SET_BITS;
            default: t.flags = $urandom();
        endcase
        return t;
    endfunction

    // all registers still at zero: every axis has unit-wide bins from zero
    task automatic test_reset_grid();
        send_triangle(make_triangle(16'sd0, 16'sd0, 16'sd0, '0));
        send_triangle(make_triangle(16'sd1, 16'sd3, 16'sd9, '0));
        send_triangle(make_triangle(16'sh7FFF, -16'sh8000, 16'sd5, '0));
        wait_drained();
    endtask

    task automatic test_box_corners();
        triangle_t t;
        load_grid(-16'sd16000, 16'sd16000, -16'sd8000, 16'sd8000, -16'sd4000, 16'sd4000);
        send_triangle(make_triangle(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '0));
        send_triangle(make_triangle(-16'sh8000, -16'sh8000, -16'sh8000, '0));
        send_triangle(make_triangle(16'sh7FFF, -16'sh8000, 16'sd0, '0));
        // right at and just past the box sentinels
        send_triangle(make_triangle(tgbm_pkg::BOX_SENTINEL, tgbm_pkg::BOX_SENTINEL + 16'sd1,
                                    tgbm_pkg::BOX_SENTINEL, '0));
        send_triangle(make_triangle(-tgbm_pkg::BOX_SENTINEL, -tgbm_pkg::BOX_SENTINEL - 16'sd1,
                                    -tgbm_pkg::BOX_SENTINEL, '0));
        send_triangle(make_triangle(-16'sd16000, -16'sd16000, -16'sd16000, '0));
        // bin edges: 32000/16 + 1 gives step 2001 on x
        t = make_triangle(16'sd2001, 16'sd4002, -16'sd14000, '0);
        t.ay = 16'sd0; t.by = 16'sd0; t.cy = 16'sd0;
        send_triangle(t);
        wait_drained();
    endtask

    task automatic test_skip_flags();
        logic [tgbm_pkg::FLAGS_W-1:0] flag_words [7];
        flag_words = '{32'h0000_0080, 32'h0000_1000,
                       tgbm_pkg::SKIP_SET_BITS | 32'h0001_0000,
                       tgbm_pkg::SKIP_SET_BITS | 32'h0800_0000, 32'hFFFF_FFFF,
                       ~tgbm_pkg::SKIP_CLEAR_BITS, 32'h0000_0000};
        foreach (flag_words[i])
            send_triangle(make_triangle(-16'sd20000, 16'sd20000, 16'sd0, flag_words[i]));
        wait_drained();
    endtask

    // limits below origins and a full-span grid whose last edge wraps
    task automatic test_wrapping_grids();
        load_grid(16'sd100, -16'sd100, -16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000);
        send_triangle(make_triangle(-16'sd300, 16'sd300, 16'sd0, '0));
        send_triangle(make_triangle(16'sh7FFF, 16'sh7FF0, 16'sh7FFF, '0));
        send_triangle(make_triangle(-16'sh8000, -16'sd1, 16'sd90, '0));
        wait_drained();
    endtask

    task automatic test_random_grid(int setting);
        int idle_modes [4][2];
        idle_modes = '{'{0, 0}, '{84, 0}, '{0, 84}, '{21, 21}};
        case (setting)
            0: load_grid(-16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
            1: load_grid(16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000);
            2:
            begin
                tgbm_pkg::coord_t xo, zo, yo;
                xo = tgbm_pkg::coord_t'($urandom_range(16'hFFFF));
                zo = tgbm_pkg::coord_t'($urandom_range(16'hFFFF));
                yo = tgbm_pkg::coord_t'($urandom_range(16'hFFFF));
                load_grid(xo, xo, zo, zo, yo, yo);
            end
            3:
            begin
                tgbm_pkg::coord_t xo, zo, yo;
                xo = tgbm_pkg::coord_t'($urandom_range(16'hFFFF));
                zo = tgbm_pkg::coord_t'($urandom_range(16'hFFFF));
                yo = tgbm_pkg::coord_t'($urandom_range(16'hFFFF));
                load_grid(xo, xo + tgbm_pkg::coord_t'($urandom_range(64)),
                          zo, zo + tgbm_pkg::coord_t'($urandom_range(64)),
                          yo, yo + tgbm_pkg::coord_t'($urandom_range(40)));
            end
            default:
                load_grid(tgbm_pkg::coord_t'($urandom_range(16'hFFFF)),
                          tgbm_pkg::coord_t'($urandom_range(16'hFFFF)),
                          tgbm_pkg::coord_t'($urandom_range(16'hFFFF)),
                          tgbm_pkg::coord_t'($urandom_range(16'hFFFF)),
                          tgbm_pkg::coord_t'($urandom_range(16'hFFFF)),
                          tgbm_pkg::coord_t'($urandom_range(16'hFFFF)));
        endcase
        for (int mode = 0; mode < 4; mode++)
        begin
            send_idle_pct = idle_modes[mode][0];
            recv_stall_pct = idle_modes[mode][1];
            for (int n = 0; n < ITEMS_PER_MODE; n++)
                send_triangle(rand_triangle());
        end
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        foreach (grid_cfg[i])
            grid_cfg[i] = '0;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        test_reset_grid();
        test_box_corners();
        test_skip_flags();
        test_wrapping_grids();
        for (int g = 0; g < 6; g++)
            test_random_grid(g);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_masks.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $realtime, pending_masks.size());
            errors++;
        end
        $display("%0d triangles over %0d grid settings, %0d words checked (%0d all-zero)",
                 triangles_sent, grid_settings, masks_checked, skipped_seen);
        $display("stalls on both sides, skip flags, sentinel clamping and wrapped edges, %0d errors",
                 errors);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
